// ===== design/projectile_slot_pool_top_defines.svh =====
`ifndef PROJECTILE_SLOT_POOL_TOP_DEFINES_SVH
`define PROJECTILE_SLOT_POOL_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define PPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pps_pkg.sv =====
`timescale 1ns / 1ps

package pps_pkg;

    // pool size default
    localparam int SLOT_COUNT_DEF = 16;

    // field widths
    localparam int POS_W    = 16;
    localparam int STEP_W   = 12;
    localparam int SIZE_W   = 8;
    localparam int SCREEN_W = 13;
    localparam int INDEX_W  = 4;

    // owner tags
    localparam logic OWNER_PLAYER = 1'b0;
    localparam logic OWNER_ENEMY  = 1'b1;

    // request modes
    localparam logic [1:0] MODE_SPAWN  = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_FREE   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // register indexes
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // register reset values
    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // contents of one slot
    typedef struct packed {
        logic              live;
        logic              owner;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
        logic [SIZE_W-1:0] size_w;
        logic [SIZE_W-1:0] size_h;
    } slot_t;

    // empty slot as left by reset
    localparam slot_t SLOT_RST = '{
        live:   1'b0,
        owner:  OWNER_PLAYER,
        pos_x:  '0,
        pos_y:  '0,
        step_x: '0,
        step_y: '0,
        size_w: 8'd1,
        size_h: 8'd1
    };

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } cell_ctl_t;

endpackage

// ===== design/pps_mover.sv =====
`timescale 1ns / 1ps

module pps_mover
    import pps_pkg::*;
(
    input  slot_t               slot_in,
    input  logic [SCREEN_W-1:0] screen_width,
    input  logic [SCREEN_W-1:0] screen_height,
    output slot_t               slot_out
);

    logic [POS_W:0]   next_x;
    logic [POS_W:0]   next_y;
    logic [POS_W+1:0] right_x;
    logic [POS_W+1:0] bottom_y;
    logic             off_left;
    logic             off_top;
    logic             off_right;
    logic             off_bottom;

    // move with one guard bit so nothing wraps
    assign next_x = {slot_in.pos_x[POS_W-1], slot_in.pos_x}
                  + {{(POS_W+1-STEP_W){slot_in.step_x[STEP_W-1]}}, slot_in.step_x};
    assign next_y = {slot_in.pos_y[POS_W-1], slot_in.pos_y}
                  + {{(POS_W+1-STEP_W){slot_in.step_y[STEP_W-1]}}, slot_in.step_y};

    // far edges of the moved box
    assign right_x  = {next_x[POS_W], next_x} + {{(POS_W+2-SIZE_W){1'b0}}, slot_in.size_w};
    assign bottom_y = {next_y[POS_W], next_y} + {{(POS_W+2-SIZE_W){1'b0}}, slot_in.size_h};

    // off-screen tests
    assign off_left   = right_x[POS_W+1] || (right_x == '0);
    assign off_top    = bottom_y[POS_W+1] || (bottom_y == '0);
    assign off_right  = $signed({next_x[POS_W], next_x})
                        >= $signed({{(POS_W+2-SCREEN_W){1'b0}}, screen_width});
    assign off_bottom = $signed({next_y[POS_W], next_y})
                        >= $signed({{(POS_W+2-SCREEN_W){1'b0}}, screen_height});

    // store saturated edges and cull
    always_comb
    begin
        slot_out = slot_in;
        if (slot_in.live)
        begin
            if (next_x[POS_W] != next_x[POS_W-1])
                slot_out.pos_x = next_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                               : {1'b0, {(POS_W-1){1'b1}}};
            else
                slot_out.pos_x = next_x[POS_W-1:0];
            if (next_y[POS_W] != next_y[POS_W-1])
                slot_out.pos_y = next_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                               : {1'b0, {(POS_W-1){1'b1}}};
            else
                slot_out.pos_y = next_y[POS_W-1:0];
            slot_out.live = !(off_left || off_top || off_right || off_bottom);
        end
    end

endmodule

// ===== design/pps_cell.sv =====
`timescale 1ns / 1ps

module pps_cell
    import pps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  slot_t     spawn_slot,
    input  slot_t     neighbor_slot,
    output slot_t     slot_q
);

    slot_t slot_reg;
    slot_t slot_next;

    // shift along the ring, take a spawn or drop the live bit
    always_comb
    begin
        slot_next = slot_reg;
        priority if (ctl.shift)
            slot_next = neighbor_slot;
        else if (ctl.load)
            slot_next = spawn_slot;
        else if (ctl.clear)
            slot_next.live = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= SLOT_RST;
        else
            slot_reg <= slot_next;
    end

    assign slot_q = slot_reg;

endmodule

// ===== design/projectile_slot_pool_top.sv =====
// spawn and free-all: one result, loaded into the output register at the accept edge
// tick: SLOT_COUNT results, one per cycle while the output is not stalled, as the
//   slot ring rotates once past a single move-and-cull unit
// a new request is taken once the tick has loaded its last beat and the output can load
// reset clears every slot (not live, player owner, zero edges and steps, size 1)
//   and sets the screen to 640 by 480; the block is ready the cycle after reset
`timescale 1ns / 1ps
`include "projectile_slot_pool_top_defines.svh"

module projectile_slot_pool_top
    import pps_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [SCREEN_W-1:0]      cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               mode,
    input  logic signed [POS_W-1:0]  spawn_x,
    input  logic signed [POS_W-1:0]  spawn_y,
    input  logic signed [STEP_W-1:0] speed_x,
    input  logic signed [STEP_W-1:0] speed_y,
    input  logic [SIZE_W-1:0]        box_width,
    input  logic [SIZE_W-1:0]        box_height,
    input  logic                     owner_tag,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [INDEX_W-1:0]       slot_index,
    output logic                     accepted,
    output logic                     slot_active,
    output logic                     slot_owner,
    output logic signed [POS_W-1:0]  now_x,
    output logic signed [POS_W-1:0]  now_y,
    output logic                     last_result
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic {S_IDLE, S_TICK} state_t;

    state_t               state_reg;
    logic [IDX_W-1:0]     count_reg;
    logic                 out_valid_reg;
    logic [INDEX_W-1:0]   slot_index_reg;
    logic                 accepted_reg;
    logic                 slot_active_reg;
    logic                 slot_owner_reg;
    logic [POS_W-1:0]     now_x_reg;
    logic [POS_W-1:0]     now_y_reg;
    logic                 last_result_reg;
    logic [SCREEN_W-1:0]  screen_width_reg;
    logic [SCREEN_W-1:0]  screen_height_reg;

    logic                 can_load;
    logic                 in_fire;
    logic                 tick_step;
    logic                 out_load;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W+3:0]     free_idx_wide;
    logic [IDX_W+3:0]     count_wide;
    slot_t                spawn_slot;
    slot_t                moved_slot;
    slot_t                ring_q [SLOT_COUNT];
    cell_ctl_t            ring_ctl [SLOT_COUNT];

    // handshake
    assign can_load  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !can_load;
    assign in_fire   = in_valid && !in_stall;
    assign tick_step = (state_reg == S_TICK) && can_load;

    // a result beat enters the output register
    assign out_load  = (in_fire && ((mode == MODE_SPAWN) || (mode == MODE_FREE)))
                       || tick_step;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!ring_q[i].live)
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign free_idx_wide = {4'b0, free_idx};
    assign count_wide    = {4'b0, count_reg};

    // new slot contents, zero size taken as one
    always_comb
    begin
        spawn_slot.live   = 1'b1;
        spawn_slot.owner  = owner_tag;
        spawn_slot.pos_x  = spawn_x;
        spawn_slot.pos_y  = spawn_y;
        spawn_slot.step_x = speed_x;
        spawn_slot.step_y = speed_y;
        spawn_slot.size_w = (box_width == '0) ? SIZE_W'(1) : box_width;
        spawn_slot.size_h = (box_height == '0) ? SIZE_W'(1) : box_height;
    end

    // move-and-cull unit at the head of the ring
    pps_mover u_mover (
        .slot_in       (ring_q[0]),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .slot_out      (moved_slot)
    );

    // ring of slot cells; the head's updated slot wraps to the tail
    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_ring
        assign ring_ctl[g].shift = tick_step;
        assign ring_ctl[g].load  = in_fire && (mode == MODE_SPAWN) && free_found
                                   && (free_idx == IDX_W'(g));
        assign ring_ctl[g].clear = in_fire && (mode == MODE_FREE);

        pps_cell u_slot (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ring_ctl[g]),
            .spawn_slot    (spawn_slot),
            .neighbor_slot ((g == SLOT_COUNT - 1) ? moved_slot
                                                  : ring_q[(g + 1) % SLOT_COUNT]),
            .slot_q        (ring_q[g])
        );
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            slot_index_reg  <= '0;
            accepted_reg    <= 1'b0;
            slot_active_reg <= 1'b0;
            slot_owner_reg  <= 1'b0;
            now_x_reg       <= '0;
            now_y_reg       <= '0;
            last_result_reg <= 1'b0;
        end
        else
        begin
            // new beat loaded, or the held beat taken downstream
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (mode)
                            MODE_SPAWN:
                            begin
                                slot_index_reg  <= free_found ? free_idx_wide[3:0] : '0;
                                accepted_reg    <= free_found;
                                slot_active_reg <= 1'b0;
                                slot_owner_reg  <= 1'b0;
                                now_x_reg       <= '0;
                                now_y_reg       <= '0;
                                last_result_reg <= 1'b1;
                            end
                            MODE_TICK:
                            begin
                                state_reg <= S_TICK;
                                count_reg <= '0;
                            end
                            MODE_FREE:
                            begin
                                slot_index_reg  <= '0;
                                accepted_reg    <= 1'b0;
                                slot_active_reg <= 1'b0;
                                slot_owner_reg  <= 1'b0;
                                now_x_reg       <= '0;
                                now_y_reg       <= '0;
                                last_result_reg <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_TICK:
                begin
                    if (tick_step)
                    begin
                        slot_index_reg  <= count_wide[3:0];
                        accepted_reg    <= 1'b0;
                        slot_active_reg <= moved_slot.live;
                        slot_owner_reg  <= moved_slot.owner;
                        now_x_reg       <= moved_slot.pos_x;
                        now_y_reg       <= moved_slot.pos_y;
                        last_result_reg <= (count_reg == LAST_SLOT);
                        if (count_reg == LAST_SLOT)
                            state_reg <= S_IDLE;
                        else
                            count_reg <= count_reg + IDX_W'(1);
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign slot_index  = slot_index_reg;
    assign accepted    = accepted_reg;
    assign slot_active = slot_active_reg;
    assign slot_owner  = slot_owner_reg;
    assign now_x       = now_x_reg;
    assign now_y       = now_y_reg;
    assign last_result = last_result_reg;

    // spawn and free-all yield a beat on the next cycle
    `PPS_ASSERT_NEXT(a_req_gives_beat, in_fire && ((mode == MODE_SPAWN) || (mode == MODE_FREE)), out_valid_reg, "request gave no result beat")

    // the final tick beat is marked and returns the sequencer to idle
    `PPS_ASSERT_NEXT(a_tick_last, tick_step && (count_reg == LAST_SLOT), (state_reg == S_IDLE) && last_result_reg && out_valid_reg, "tick did not end on a marked beat")

    // a beat in the middle of a tick is never marked last
    `PPS_ASSERT_NEXT(a_tick_mid, tick_step && (count_reg != LAST_SLOT), (state_reg == S_TICK) && !last_result_reg, "tick beat marked last too early")

    // the ring only rotates while a tick is running
    `PPS_ASSERT_IMPL(a_shift_in_tick, ring_ctl[0].shift, (state_reg == S_TICK) && !in_fire, "slot ring rotated outside a tick")

endmodule

// ===== bench/projectile_slot_pool_top_tb.sv =====
`timescale 1ns / 1ps

module projectile_slot_pool_top_tb;

    import pps_pkg::*;

    localparam int POOL_SLOTS     = SLOT_COUNT_DEF;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_PHASE = 3;

    // one request beat
    typedef struct {
        logic [1:0]              mode;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [STEP_W-1:0] vx;
        logic signed [STEP_W-1:0] vy;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
        logic                     owner;
    } pool_req_t;

    // one report beat
    typedef struct {
        logic [INDEX_W-1:0]      slot;
        logic                    acc;
        logic                    act;
        logic                    own;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic                    last;
    } pool_report_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic                     cfg_index = REG_SCREEN_WIDTH;
    logic [SCREEN_W-1:0]      cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               mode = MODE_SPAWN;
    logic signed [POS_W-1:0]  spawn_x = '0;
    logic signed [POS_W-1:0]  spawn_y = '0;
    logic signed [STEP_W-1:0] speed_x = '0;
    logic signed [STEP_W-1:0] speed_y = '0;
    logic [SIZE_W-1:0]        box_width = '0;
    logic [SIZE_W-1:0]        box_height = '0;
    logic                     owner_tag = OWNER_PLAYER;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [INDEX_W-1:0]       slot_index;
    logic                     accepted;
    logic                     slot_active;
    logic                     slot_owner;
    logic signed [POS_W-1:0]  now_x;
    logic signed [POS_W-1:0]  now_y;
    logic                     last_result;

    // bench state
    pool_req_t     requests_pending[$];
    pool_report_t  reports_due[$];
    slot_t         pool_model[POOL_SLOTS];
    logic [SCREEN_W-1:0] scr_w;
    logic [SCREEN_W-1:0] scr_h;
    pool_req_t     taken_req;
    logic          in_beat = 1'b0;
    int            send_pct = 0;
    int            recv_pct = 0;
    int            phase_no = 0;
    int            mismatch_count = 0;
    int            quiet_cycles = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;

    projectile_slot_pool_top #(
        .SLOT_COUNT (POOL_SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .spawn_x     (spawn_x),
        .spawn_y     (spawn_y),
        .speed_x     (speed_x),
        .speed_y     (speed_y),
        .box_width   (box_width),
        .box_height  (box_height),
        .owner_tag   (owner_tag),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot_index  (slot_index),
        .accepted    (accepted),
        .slot_active (slot_active),
        .slot_owner  (slot_owner),
        .now_x       (now_x),
        .now_y       (now_y),
        .last_result (last_result)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // clamp a wide position into 16 bits
    function automatic logic [POS_W-1:0] clamp16(input int v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return POS_W'(v);
    endfunction

    // report with every field zero except the ones given, and last set
    function automatic pool_report_t plain_report(input logic [INDEX_W-1:0] slot,
                                                  input logic acc);
        pool_report_t rep;
        rep.slot = slot;
        rep.acc  = acc;
        rep.act  = 1'b0;
        rep.own  = 1'b0;
        rep.px   = '0;
        rep.py   = '0;
        rep.last = 1'b1;
        return rep;
    endfunction

    // apply one accepted request to the pool and queue the reports it causes
    task automatic advance_pool(input pool_req_t r);
        pool_report_t rep;
        int           nx;
        int           ny;
        int           found;
        logic         off;
        found = -1;
        case (r.mode)
            MODE_SPAWN:
            begin
                for (int i = 0; i < POOL_SLOTS; i++)
                begin
                    if (found < 0 && !pool_model[i].live)
                        found = i;
                end
                if (found >= 0)
                begin
                    pool_model[found].live   = 1'b1;
                    pool_model[found].owner  = r.owner;
                    pool_model[found].pos_x  = r.x;
                    pool_model[found].pos_y  = r.y;
                    pool_model[found].step_x = r.vx;
                    pool_model[found].step_y = r.vy;
                    pool_model[found].size_w = (r.w == '0) ? 8'd1 : r.w;
                    pool_model[found].size_h = (r.h == '0) ? 8'd1 : r.h;
                    reports_due.push_back(plain_report(INDEX_W'(found), 1'b1));
                end
                else
                begin
                    reports_due.push_back(plain_report('0, 1'b0));
                end
            end
            MODE_TICK:
            begin
                for (int i = 0; i < POOL_SLOTS; i++)
                begin
                    if (pool_model[i].live)
                    begin
                        nx = int'($signed(pool_model[i].pos_x)) +
                             int'($signed(pool_model[i].step_x));
                        ny = int'($signed(pool_model[i].pos_y)) +
                             int'($signed(pool_model[i].step_y));
                        off = (nx + int'(pool_model[i].size_w) <= 0) ||
                              (ny + int'(pool_model[i].size_h) <= 0) ||
                              (nx >= int'(scr_w)) || (ny >= int'(scr_h));
                        pool_model[i].pos_x = clamp16(nx);
                        pool_model[i].pos_y = clamp16(ny);
                        if (off)
                            pool_model[i].live = 1'b0;
                    end
                    rep.slot = INDEX_W'(i);
                    rep.acc  = 1'b0;
                    rep.act  = pool_model[i].live;
                    rep.own  = pool_model[i].owner;
                    rep.px   = pool_model[i].pos_x;
                    rep.py   = pool_model[i].pos_y;
                    rep.last = (i == POOL_SLOTS - 1);
                    reports_due.push_back(rep);
                end
            end
            MODE_FREE:
            begin
                for (int i = 0; i < POOL_SLOTS; i++)
                    pool_model[i].live = 1'b0;
                reports_due.push_back(plain_report('0, 1'b0));
            end
            default:
            begin
            end
        endcase
    endtask

    // compare one report beat against the oldest expected one
    task automatic match_report;
        pool_report_t want;
        if (reports_due.size() == 0)
        begin
            $error("report beat with nothing expected: slot_index %0d", slot_index);
            mismatch_count++;
        end
        else
        begin
            want = reports_due.pop_front();
            if (slot_index !== want.slot)
            begin
                $error("slot_index expected %0d got %0d", want.slot, slot_index);
                mismatch_count++;
            end
            if (accepted !== want.acc)
            begin
                $error("accepted expected %0d got %0d", want.acc, accepted);
                mismatch_count++;
            end
            if (slot_active !== want.act)
            begin
                $error("slot_active expected %0d got %0d", want.act, slot_active);
                mismatch_count++;
            end
            if (slot_owner !== want.own)
            begin
                $error("slot_owner expected %0d got %0d", want.own, slot_owner);
                mismatch_count++;
            end
            if (now_x !== want.px)
            begin
                $error("now_x expected %0d got %0d", want.px, now_x);
                mismatch_count++;
            end
            if (now_y !== want.py)
            begin
                $error("now_y expected %0d got %0d", want.py, now_y);
                mismatch_count++;
            end
            if (last_result !== want.last)
            begin
                $error("last_result expected %0d got %0d", want.last, last_result);
                mismatch_count++;
            end
        end
    endtask

    // monitor: check reports, then predict from accepted requests
    always @(posedge clk)
    begin
        in_beat <= rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
            match_report();
        if (rst_n && in_valid && !in_stall)
        begin
            taken_req.mode  = mode;
            taken_req.x     = spawn_x;
            taken_req.y     = spawn_y;
            taken_req.vx    = speed_x;
            taken_req.vy    = speed_y;
            taken_req.w     = box_width;
            taken_req.h     = box_height;
            taken_req.owner = owner_tag;
            advance_pool(taken_req);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("projectile_slot_pool_top: mismatch");
            $finish;
        end
    end

    // request driver fed from the pending queue
    always @(negedge clk)
    begin
        if (in_beat)
            void'(requests_pending.pop_front());
        if (!in_valid || in_beat)
        begin
            if (rst_n && requests_pending.size() != 0 && $urandom_range(99) >= send_pct)
            begin
                in_valid   <= 1'b1;
                mode       <= requests_pending[0].mode;
                spawn_x    <= requests_pending[0].x;
                spawn_y    <= requests_pending[0].y;
                speed_x    <= requests_pending[0].vx;
                speed_y    <= requests_pending[0].vy;
                box_width  <= requests_pending[0].w;
                box_height <= requests_pending[0].h;
                owner_tag  <= requests_pending[0].owner;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // report receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n && phase_no == PRESSURE_PHASE && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // queue a spawn with the given content
    task automatic queue_spawn(input logic signed [POS_W-1:0] x,
                               input logic signed [POS_W-1:0] y,
                               input logic signed [STEP_W-1:0] vx,
                               input logic signed [STEP_W-1:0] vy,
                               input logic [SIZE_W-1:0] w,
                               input logic [SIZE_W-1:0] h,
                               input logic owner);
        pool_req_t r;
        r.mode  = MODE_SPAWN;
        r.x     = x;
        r.y     = y;
        r.vx    = vx;
        r.vy    = vy;
        r.w     = w;
        r.h     = h;
        r.owner = owner;
        requests_pending.push_back(r);
    endtask

    // queue a non-spawn request with junk in the other fields
    task automatic queue_op(input logic [1:0] op);
        pool_req_t r;
        r.mode  = op;
        r.x     = POS_W'($urandom);
        r.y     = POS_W'($urandom);
        r.vx    = STEP_W'($urandom);
        r.vy    = STEP_W'($urandom);
        r.w     = SIZE_W'($urandom);
        r.h     = SIZE_W'($urandom);
        r.owner = 1'($urandom_range(1));
        requests_pending.push_back(r);
    endtask

    // position mostly around the visible area
    function automatic int near_edge(input logic [SCREEN_W-1:0] extent);
        return int'($urandom_range(int'(extent) + 350)) - 300;
    endfunction

    // random mix of spawns and ticks with some free-all and unused modes
    task automatic queue_random(input int count);
        pool_req_t r;
        int        pick;
        int        done;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                r.mode = MODE_SPAWN;
            else if (pick < 84)
                r.mode = MODE_TICK;
            else if (pick < 93)
                r.mode = MODE_FREE;
            else
                r.mode = MODE_UNUSED;
            if ($urandom_range(99) < 65)
            begin
                r.x = POS_W'(near_edge(scr_w));
                r.y = POS_W'(near_edge(scr_h));
            end
            else
            begin
                r.x = POS_W'($urandom);
                r.y = POS_W'($urandom);
            end
            if ($urandom_range(99) < 75)
            begin
                r.vx = STEP_W'(int'($urandom_range(40)) - 20);
                r.vy = STEP_W'(int'($urandom_range(40)) - 20);
            end
            else
            begin
                r.vx = STEP_W'($urandom);
                r.vy = STEP_W'($urandom);
            end
            r.w     = ($urandom_range(99) < 10) ? '0 : SIZE_W'($urandom);
            r.h     = ($urandom_range(99) < 10) ? '0 : SIZE_W'($urandom);
            r.owner = 1'($urandom_range(1));
            requests_pending.push_back(r);
            if (r.mode != MODE_UNUSED)
                done++;
        end
    endtask

    // register write, only while the block is idle
    task automatic write_screen(input logic idx, input logic [SCREEN_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)
            scr_w = val;
        else
            scr_h = val;
    endtask

    // wait for every request taken and every report seen, then settle
    task automatic wait_drained;
        do
            @(negedge clk);
        while (requests_pending.size() != 0 || in_valid || reports_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one random phase with its own screen and idling
    task automatic run_phase(input int ph, input logic [SCREEN_W-1:0] w,
                             input logic [SCREEN_W-1:0] h, input int spct,
                             input int rpct, input int count);
        write_screen(REG_SCREEN_WIDTH, w);
        write_screen(REG_SCREEN_HEIGHT, h);
        send_pct = spct;
        recv_pct = rpct;
        phase_no = ph;
        queue_random(count);
        wait_drained();
    endtask

    // sequence of phases
    initial
    begin
        for (int i = 0; i < POOL_SLOTS; i++)
            pool_model[i] = SLOT_RST;
        scr_w = SCREEN_WIDTH_RST;
        scr_h = SCREEN_HEIGHT_RST;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty pool, edge boxes, full pool, unused mode
        queue_op(MODE_FREE);
        queue_op(MODE_TICK);
        queue_spawn(16'sd0, 16'sd0, 12'sd0, 12'sd0, 8'd0, 8'd0, OWNER_PLAYER);
        queue_spawn(16'sd32767, 16'sd100, 12'sd2047, 12'sd0, 8'd255, 8'd255, OWNER_ENEMY);
        queue_spawn(-16'sd32768, 16'sd100, -12'sd2048, 12'sd0, 8'd255, 8'd255,
                    OWNER_ENEMY);
        queue_spawn(16'sd100, 16'sd32767, 12'sd0, 12'sd2047, 8'd1, 8'd1, OWNER_PLAYER);
        queue_spawn(16'sd100, -16'sd32768, 12'sd0, -12'sd2048, 8'd1, 8'd1, OWNER_ENEMY);
        queue_spawn(-16'sd255, 16'sd10, 12'sd0, 12'sd0, 8'd255, 8'd4, OWNER_PLAYER);
        queue_spawn(-16'sd254, 16'sd10, 12'sd0, 12'sd0, 8'd255, 8'd4, OWNER_ENEMY);
        queue_spawn(16'sd10, -16'sd255, 12'sd0, 12'sd0, 8'd4, 8'd255, OWNER_PLAYER);
        queue_spawn(16'sd639, 16'sd10, 12'sd0, 12'sd0, 8'd2, 8'd2, OWNER_ENEMY);
        queue_spawn(16'sd10, 16'sd479, 12'sd0, 12'sd0, 8'd2, 8'd2, OWNER_PLAYER);
        queue_spawn(16'sd640, 16'sd10, 12'sd0, 12'sd0, 8'd2, 8'd2, OWNER_ENEMY);
        queue_spawn(16'sd10, 16'sd480, 12'sd0, 12'sd0, 8'd2, 8'd2, OWNER_PLAYER);
        queue_spawn(-16'sd1, -16'sd1, 12'sd1, 12'sd1, 8'd0, 8'd0, OWNER_ENEMY);
        queue_spawn(-16'sd1, 16'sd5, 12'sd0, 12'sd0, 8'd0, 8'd3, OWNER_PLAYER);
        queue_spawn(16'sd200, 16'sd200, -12'sd2048, 12'sd2047, 8'd128, 8'd1,
                    OWNER_ENEMY);
        queue_spawn(16'sd300, 16'sd300, 12'sd5, -12'sd5, 8'd16, 8'd16, OWNER_ENEMY);
        // pool is full here
        queue_spawn(16'sd50, 16'sd50, 12'sd1, 12'sd1, 8'd8, 8'd8, OWNER_ENEMY);
        queue_op(MODE_TICK);
        queue_op(MODE_UNUSED);
        queue_op(MODE_TICK);
        queue_op(MODE_FREE);
        queue_spawn(16'sd20, 16'sd20, 12'sd3, 12'sd3, 8'd10, 8'd10, OWNER_ENEMY);
        queue_op(MODE_TICK);
        wait_drained();

        // random phases over screen settings and idling patterns
        run_phase(1, 13'd4096, 13'd4096, 0, 0, 65);
        run_phase(2, 13'd1, 13'd1, 56, 0, 55);
        run_phase(PRESSURE_PHASE, 13'd320, 13'd200, 0, 56, 65);
        run_phase(4, 13'd0, 13'd8191, 20, 20, 55);
        run_phase(5, 13'd8191, 13'd0, 0, 0, 50);
        run_phase(6, SCREEN_W'($urandom_range(4096, 1)), SCREEN_W'($urandom_range(4096, 1)),
                  20, 20, 55);

        if (mismatch_count == 0)
            $display("projectile_slot_pool_top: match");
        else
            $display("projectile_slot_pool_top: mismatch");
        $finish;
    end

endmodule
